// ----- hw/rtl/shb_pkg.sv -----
package shb_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_W   = 32;

    // multiplier applied per byte
    localparam logic [SEED_W-1:0] HASH_MULT = 32'd341;

    // ascii upper-case range and fold offset
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE    = 8'h20;

    // remainder unit runs one quotient bit per cycle
    localparam int unsigned DIV_STEPS = SEED_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic
    {
        REG_HASH_SEED    = 1'b0,
        REG_BUCKET_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } seq_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

// ----- hw/rtl/shb_if.sv -----
interface shb_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       char_valid;
    logic       last;

    modport source (output valid, output char_byte, output char_valid, output last,
                    input ready);
    modport sink   (input valid, input char_byte, input char_valid, input last,
                    output ready);
endinterface

interface shb_index_if;
    logic        valid;
    logic        ready;
    logic [30:0] bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

// ----- hw/rtl/shb_hash_acc.sv -----
module shb_hash_acc
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [shb_pkg::BYTE_W-1:0]   char_byte,
    input  logic                         char_valid,
    input  logic                         last,
    input  logic [shb_pkg::SEED_W-1:0]   seed,
    output logic [shb_pkg::SEED_W-1:0]   acc
);
    import shb_pkg::*;

    logic [SEED_W-1:0] acc_reg;
    logic [SEED_W-1:0] acc_next;
    logic              in_string_reg;
    logic              in_string_next;
    logic [SEED_W-1:0] base;
    logic [BYTE_W-1:0] folded;

    // lower-case fold of ascii letters only
    always_comb
    begin
        if (char_byte >= ASCII_UPPER_A && char_byte <= ASCII_UPPER_Z)
        begin
            folded = char_byte + ASCII_CASE;
        end
        else
        begin
            folded = char_byte;
        end
    end

    always_comb
    begin
        base           = in_string_reg ? acc_reg : seed;
        acc_next       = acc_reg;
        in_string_next = in_string_reg;
        if (step)
        begin
            acc_next = base;
            if (char_valid)
            begin
                acc_next = base * HASH_MULT + {{(SEED_W-BYTE_W){1'b0}}, folded};
            end
            in_string_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            in_string_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            in_string_reg <= in_string_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/shb_mod_unit.sv -----
module shb_mod_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [shb_pkg::SEED_W-1:0]    dividend,
    input  logic [shb_pkg::LIMIT_W-1:0]   divisor,
    output shb_pkg::mod_status_t          status,
    output logic [shb_pkg::LIMIT_W-1:0]   remainder
);
    import shb_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SEED_W-1:0]    quo_reg;
    logic [LIMIT_W-1:0]   rem_reg;
    logic [LIMIT_W-1:0]   div_reg;
    logic [SEED_W-1:0]    rem_shift;
    logic [SEED_W-1:0]    rem_diff;
    logic [LIMIT_W-1:0]   rem_next;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SEED_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        if (rem_shift >= {1'b0, div_reg})
        begin
            rem_next = rem_diff[LIMIT_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS-1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SEED_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

// ----- hw/rtl/string_hash_bucket_index_core.sv -----
// string hash to bucket index
//
// char_item carries one string byte per transaction (char_byte, char_valid,
// last). bytes are hashed at one transaction per cycle while char_item is
// ready: the accumulator is loaded from hash_seed at string start, ascii
// capitals fold to lower case and acc = acc*341 + byte wraps at 32 bits.
// a transaction with char_valid and last both low is taken and ignored.
// the transaction with last set starts the reduction: magnitude of the
// accumulator, then remainder by (bucket_limit-1) in a restoring remainder
// unit that retires one bit per cycle, then plus one, into the output
// register that drives bucket_item; char_item is not ready from the last
// transaction until the result is handed to that register.
// the result sits in an output register; while it waits for the receiver the
// next string's bytes are accepted, and a second reduction holds its result
// in the remainder unit until the output register frees up.
// cfg_we/cfg_index/cfg_data write hash_seed (index 0) and bucket_limit
// (index 1); write only while idle. a limit below 2 acts as 2.
// reset: hash_seed 0, bucket_limit 2, no string open, output empty.
module string_hash_bucket_index_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  shb_pkg::reg_index_t         cfg_index,
    input  logic [shb_pkg::CFG_W-1:0]   cfg_data,
    shb_char_if.sink                    char_item,
    shb_index_if.source                 bucket_item
);
    import shb_pkg::*;

    // configuration registers
    logic [SEED_W-1:0]  seed_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // sequencer
    seq_state_t state_reg;
    seq_state_t state_next;

    // output holding register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [LIMIT_W-1:0] out_index_reg;
    logic               out_load;

    // hash datapath and remainder unit hookup
    logic               accept;
    logic               step;
    logic [SEED_W-1:0]  acc;
    logic [SEED_W-1:0]  mag;
    logic [LIMIT_W-1:0] lim;
    logic [LIMIT_W-1:0] divisor;
    logic               div_start;
    mod_status_t        div_status;
    logic [LIMIT_W-1:0] remainder;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            limit_reg <= LIMIT_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HASH_SEED:    seed_reg  <= cfg_data[SEED_W-1:0];
                REG_BUCKET_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    assign char_item.ready = (state_reg == ST_IDLE);
    assign accept          = char_item.valid && char_item.ready;
    // idle transactions leave the hash untouched
    assign step            = accept && (char_item.char_valid || char_item.last);

    shb_hash_acc u_hash_acc
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_byte  (char_item.char_byte),
        .char_valid (char_item.char_valid),
        .last       (char_item.last),
        .seed       (seed_reg),
        .acc        (acc)
    );

    // magnitude; the most negative value comes out as 2^31 unsigned
    assign mag     = acc[SEED_W-1] ? (SEED_W'(0) - acc) : acc;
    assign lim     = (limit_reg < LIMIT_W'(2)) ? LIMIT_W'(2) : limit_reg;
    assign divisor = lim - LIMIT_W'(1);

    shb_mod_unit u_mod_unit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag),
        .divisor   (divisor),
        .status    (div_status),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next     = state_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;
        if (bucket_item.valid && bucket_item.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                // accumulator takes the final byte this cycle
                if (accept && char_item.last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // hand over once the output register is free or being drained
                if (div_status.done && !div_status.busy &&
                    (!out_valid_reg || bucket_item.ready))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= remainder + LIMIT_W'(1);
        end
    end

    assign bucket_item.valid        = out_valid_reg;
    assign bucket_item.bucket_index = out_index_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import shb_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 40;     // drain wait, long enough to span a reduction
    localparam int HOLD_CYCLES  = 500;    // long receiver hold-off
    localparam int PHASE_ITEMS  = 220;    // hashed transactions per random phase, at least
    localparam int N_PHASES     = 7;
    localparam int NO_RESULT    = -1;     // table entry: take the expectation from the predictor
    localparam int MAX_REPORTS  = 10;

    // one row of the directed table: either a register write or a char transaction
    typedef struct packed
    {
        logic       is_cfg;
        reg_index_t reg_sel;
        logic [31:0] data;
        logic [7:0] char_byte;
        logic       char_valid;
        logic       last;
        int         want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    reg_index_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    shb_char_if  char_if ();
    shb_index_if idx_if ();

    string_hash_bucket_index_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .char_item   (char_if),
        .bucket_item (idx_if)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the block state
    logic [31:0] seed_q;
    logic [30:0] limit_q;
    logic [31:0] hash_acc;
    bit          string_open;

    // bucket indexes still owed by the block, oldest first
    logic [30:0] bucket_q [$];

    int cur_want;            // typed expectation for the transaction on the bus
    int n_errors;
    int n_cycles;
    int n_sent;              // hashed (non-idle) transactions accepted
    int n_idle;
    int n_results;
    int n_cfg;
    bit hold_req;
    bit steady;              // sender runs without gaps
    int burst_left;

    logic [30:0] bucket_pred;
    logic [30:0] bucket_want;

    // directed table
    // after reset the limit is 2, so every index is 1; the extremes below are worked by hand
    dir_row_t dir_tab [0:33] = '{
        // empty string right after reset hashes the reset seed
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 1},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h41, 1'b1, 1'b0, NO_RESULT},
        // idle transaction in mid-string
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b1, 1},
        // widest limit, most negative seed: magnitude 2^31
        '{1'b1, REG_BUCKET_LIMIT, 32'h7FFF_FFFF,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_HASH_SEED,    32'h8000_0000,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 3},
        '{1'b1, REG_HASH_SEED,    32'h7FFF_FFFF,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 2},
        '{1'b1, REG_HASH_SEED,    32'hFFFF_FFFF,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 2},
        // single bytes from seed 0: index is folded byte plus one
        '{1'b1, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h5A, 1'b1, 1'b1, 123},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h61, 1'b1, 1'b1, 98},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h41, 1'b1, 1'b1, 98},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h40, 1'b1, 1'b1, 65},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h5B, 1'b1, 1'b1, 92},
        // high bytes stay unsigned and unfolded
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hC1, 1'b1, 1'b1, 194},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b1, 256},
        // bytes then an empty-string end closes the string
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h48, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h69, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, NO_RESULT},
        // seed written in mid-string applies from the next string on
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h78, 1'b1, 1'b0, NO_RESULT},
        '{1'b1, REG_HASH_SEED,    32'h1234_5678,  8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h79, 1'b1, 1'b1, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 32'h1234_5679},
        // accumulator wraps
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'hFF, 1'b1, 1'b1, NO_RESULT},
        // limits below 2 act as 2
        '{1'b1, REG_BUCKET_LIMIT, 32'h1,          8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h71, 1'b1, 1'b1, 1},
        '{1'b1, REG_BUCKET_LIMIT, 32'h0,          8'h00, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_HASH_SEED,    32'h0,          8'h00, 1'b0, 1'b1, 1}
    };

    // seed and limit per random phase; some random phases put random bits on cfg_data
    logic [31:0] ph_seed  [N_PHASES];
    logic [31:0] ph_limit [N_PHASES];

    // predictor: hashes one transaction, returns 1 when it closes a string
    function automatic bit hash_char(input logic [7:0] b, input logic cv, input logic lst,
                                     output logic [30:0] idx);
        logic [7:0]  folded;
        logic [31:0] mag;
        logic [31:0] modulus;
        idx = '0;
        // idle transaction: no effect at all
        if (!cv && !lst)
            return 1'b0;
        // string start loads the seed
        if (!string_open)
        begin
            hash_acc    = seed_q;
            string_open = 1'b1;
        end
        if (cv)
        begin
            folded = (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ? b + ASCII_CASE : b;
            hash_acc = hash_acc * HASH_MULT + {24'd0, folded};
        end
        if (!lst)
            return 1'b0;
        string_open = 1'b0;
        // magnitude as unsigned, so -2^31 becomes 2^31
        mag = hash_acc[31] ? -hash_acc : hash_acc;
        modulus = (limit_q < 31'd2) ? 32'd1 : {1'b0, limit_q} - 32'd1;
        idx = 31'((mag % modulus) + 32'd1);
        return 1'b1;
    endfunction

    // byte picker biased toward letters and the fold boundaries
    function automatic logic [7:0] pick_byte();
        logic [7:0] bound_bytes [10];
        bound_bytes = '{8'h00, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'hFF};
        case ($urandom_range(0, 5))
            0:       return 8'($urandom);
            1:       return 8'(ASCII_UPPER_A + $urandom_range(0, 25));
            2:       return 8'(8'h61 + $urandom_range(0, 25));
            3:       return bound_bytes[$urandom_range(0, 9)];
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // monitor: predictor, register mirror and scoreboard, all at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seed_q      = 32'd0;
            limit_q     = 31'd2;
            hash_acc    = 32'd0;
            string_open = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HASH_SEED:    seed_q  = cfg_data;
                    REG_BUCKET_LIMIT: limit_q = cfg_data[30:0];
                    default:          ;
                endcase
            end
            // char transaction accepted
            if (char_if.valid && char_if.ready)
            begin
                if (hash_char(char_if.char_byte, char_if.char_valid, char_if.last, bucket_pred))
                    bucket_q.push_back(cur_want >= 0 ? 31'(cur_want) : bucket_pred);
            end
            // bucket transaction accepted
            if (idx_if.valid && idx_if.ready)
            begin
                n_results++;
                if (bucket_q.size() == 0)
                begin
                    if (n_errors < MAX_REPORTS)
                        $display("%0t: unexpected bucket_index %0d", $realtime,
                                 idx_if.bucket_index);
                    n_errors++;
                end
                else
                begin
                    bucket_want = bucket_q.pop_front();
                    if (bucket_want !== idx_if.bucket_index)
                    begin
                        if (n_errors < MAX_REPORTS)
                            $display("%0t: bucket_index mismatch: expected %0d, got %0d",
                                     $realtime, bucket_want, idx_if.bucket_index);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     n_cycles, bucket_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: changes ready at the falling edge; one long hold-off on request,
    // otherwise stretches of always-ready, random stalls and a rotating stall pattern
    initial
    begin : receiver
        int       hold_left;
        bit       hold_taken;
        int       mode;
        int       mode_left;
        logic [7:0] stall_pat;
        hold_left  = 0;
        hold_taken = 1'b0;
        mode       = 0;
        mode_left  = 0;
        stall_pat  = 8'hFF;
        idx_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                idx_if.ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                    stall_pat = 8'($urandom) | 8'h01;
                end
                else
                    mode_left--;
                case (mode)
                    0: idx_if.ready = 1'b1;
                    1: idx_if.ready = 1'($urandom_range(0, 1));
                    2: idx_if.ready = ($urandom_range(0, 9) != 0);
                    default:
                    begin
                        idx_if.ready = stall_pat[0];
                        stall_pat    = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
        end
    end

    // sender pacing: unless steady, bursts of random length, gaps short or long enough to span a reduction
    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            char_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 16);
        end
    endtask

    // offers one char transaction from a falling edge; once it is accepted, waits for
    // the next falling edge and then paces the sender
    task automatic drive_char(input logic [7:0] b, input logic cv, input logic lst,
                              input int want);
        char_if.valid      = 1'b1;
        char_if.char_byte  = b;
        char_if.char_valid = cv;
        char_if.last       = lst;
        cur_want           = want;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        @(negedge clk);
        if (cv || lst)
            n_sent++;
        else
            n_idle++;
        pace();
    endtask

    // sender pause until every owed index has come back
    task automatic wait_drained();
        char_if.valid = 1'b0;
        while (bucket_q.size() != 0)
            @(negedge clk);
    endtask

    // register write while the block is idle: waits until every owed index has come back,
    // then lets a further drain wait pass before writing
    task automatic write_reg(input reg_index_t sel, input logic [31:0] data);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        n_cfg++;
    endtask

    // one well-formed string with random content, with idle noise mixed in
    task automatic send_string();
        int len;
        bit empty_end;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
        empty_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                drive_char(8'($urandom), 1'b0, 1'b0, NO_RESULT);
            drive_char(pick_byte(), 1'b1, (k == len - 1) && !empty_end, NO_RESULT);
        end
        // empty-string end, with a junk byte that must be ignored
        if (empty_end)
            drive_char(8'($urandom), 1'b0, 1'b1, NO_RESULT);
        if ($urandom_range(0, 7) == 0)
            drive_char(8'($urandom), 1'b0, 1'b0, NO_RESULT);
    endtask

    // main stimulus
    initial
    begin : stimulus
        int  start;
        bit  drained_once;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_HASH_SEED;
        cfg_data           = '0;
        char_if.valid      = 1'b0;
        char_if.char_byte  = '0;
        char_if.char_valid = 1'b0;
        char_if.last       = 1'b0;
        cur_want           = NO_RESULT;
        n_errors           = 0;
        n_cycles           = 0;
        n_sent             = 0;
        n_idle             = 0;
        n_results          = 0;
        n_cfg              = 0;
        hold_req           = 1'b0;
        steady             = 1'b0;
        burst_left         = 0;
        drained_once       = 1'b0;

        ph_seed[0]  = $urandom;      ph_limit[0] = $urandom;
        ph_seed[1]  = 32'h8000_0000; ph_limit[1] = 32'h7FFF_FFFF;
        ph_seed[2]  = 32'h7FFF_FFFF; ph_limit[2] = 32'h2;
        ph_seed[3]  = $urandom;      ph_limit[3] = 32'(3 + $urandom_range(0, 30));
        ph_seed[4]  = 32'hFFFF_FFFF; ph_limit[4] = 32'd256;
        ph_seed[5]  = $urandom;      ph_limit[5] = 32'h8000_0000 | $urandom;
        ph_seed[6]  = 32'h0;         ph_limit[6] = 32'(2 + $urandom_range(0, 1000));

        // reset held low, then released at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
                write_reg(dir_tab[k].reg_sel, dir_tab[k].data);
            else
                drive_char(dir_tab[k].char_byte, dir_tab[k].char_valid, dir_tab[k].last,
                           dir_tab[k].want);
        end
        cur_want = NO_RESULT;

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_reg(REG_HASH_SEED, ph_seed[ph]);
            write_reg(REG_BUCKET_LIMIT, ph_limit[ph]);
            steady = (ph == 1) || (ph == 5);
            // receiver goes quiet for a long stretch while strings keep coming
            if (ph == 2)
                hold_req = 1'b1;
            start = n_sent;
            while (n_sent - start < PHASE_ITEMS)
            begin
                send_string();
                if (ph == 4 && !drained_once && n_sent - start > 100)
                begin
                    wait_drained();
                    drained_once = 1'b1;
                end
                else if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end

        // let everything owed come back, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d hashed and %0d idle char transactions, %0d bucket indexes",
                 n_sent, n_idle, n_results);
        $display("summary: %0d register writes over %0d settings, %0d mismatches",
                 n_cfg, N_PHASES + 5, n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/shb_pkg.sv
hw/rtl/shb_if.sv
hw/rtl/shb_hash_acc.sv
hw/rtl/shb_mod_unit.sv
hw/rtl/string_hash_bucket_index_core.sv
verif/tb.sv
